/* rtl/mcm_pkg.sv */
// Shared types, codes and constant tables of the MIDI control mapper.
package mcm_pkg;

  // Route count and the index width that follows from it
  localparam int ROUTES = 16;
  localparam int RIDX_W = (ROUTES > 1) ? $clog2(ROUTES) : 1;

  // Fixed point: FxOne means 1.0
  localparam int FxOne  = 32768;
  localparam int Div127 = 127;
  localparam int Rnd127 = Div127 / 2;
  localparam logic [15:0] ONE_FX  = 16'(FxOne);
  localparam logic [15:0] HALF_FX = 16'(FxOne / 2);

  // Bend scaling by 1/16383, done as a fold since 2^14 is one above the divisor
  localparam logic [15:0] BEND_DIV  = 16'd16383;
  localparam logic [15:0] BEND_DIV2 = 16'd32766;
  localparam logic [15:0] BEND_RND  = 16'd8191;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_MSG   = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    MSG_OTHER    = 3'd0,
    MSG_NOTE_OFF = 3'd1,
    MSG_NOTE_ON  = 3'd2,
    MSG_CC       = 3'd3,
    MSG_BEND     = 3'd4
  } msg_type_e;

  typedef enum logic [2:0] {
    EVT_CC_ABS    = 3'd0,
    EVT_CC_REL    = 3'd1,
    EVT_BEND      = 3'd2,
    EVT_MOMENTARY = 3'd3,
    EVT_TOGGLE    = 3'd4,
    EVT_VELOCITY  = 3'd5
  } route_evt_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WALK = 2'd1,
    S_DONE = 2'd2
  } state_e;

  // One route table entry, 17 bits
  typedef struct packed {
    logic       enable;
    logic       port;
    logic [4:0] channel;
    route_evt_e evt;
    logic [6:0] number;
  } route_t;

  localparam int ROUTE_W = $bits(route_t);

  // Decoded MIDI message held for the route walk
  typedef struct packed {
    logic       port;
    msg_type_e  mtype;
    logic [3:0] chan;
    logic [6:0] d1;
    logic [6:0] d2;
  } msg_t;

  // Update unit result for one route
  typedef struct packed {
    logic        hit;
    logic [15:0] value;
  } upd_t;

  typedef logic        [15:0] lut7_t  [128];
  typedef logic signed [15:0] dlut7_t [128];

  // round(d * 32768 / 127) for a 7-bit value
  function automatic lut7_t build_scale7();
    lut7_t lut;
    int    x;
    for (int d = 0; d < 128; d++) begin
      x      = d * FxOne + Rnd127;
      lut[d] = 16'(x / Div127);
    end
    return lut;
  endfunction

  // floor((s * 32768 + 63) / 127) for the sign-magnitude relative step (bit 6 is the sign)
  function automatic dlut7_t build_rel_delta();
    dlut7_t lut;
    int     s;
    int     x;
    int     q;
    for (int d = 0; d < 128; d++) begin
      s = (d >= 64) ? (64 - d) : d;
      x = s * FxOne + Rnd127;
      if (x >= 0) begin
        q = x / Div127;
      end else begin
        q = -((-x + Div127 - 1) / Div127);
      end
      lut[d] = 16'(q);
    end
    return lut;
  endfunction

  localparam lut7_t  SCALE7_LUT    = build_scale7();
  localparam dlut7_t REL_DELTA_LUT = build_rel_delta();

endpackage

/* rtl/mcm_ram.sv */
// Single-port-write, registered-read RAM with per-entry valid bits cleared at reset.
module mcm_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [Width-1:0] rdata_q;
  logic             rvalid_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // Mark written entries; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

/* rtl/mcm_update.sv */
// Route match and value update for one route against the held MIDI message.
module mcm_update import mcm_pkg::*; (
  input  route_t      route_i,
  input  logic [15:0] old_i,
  input  msg_t        msg_i,
  output upd_t        upd_o
);

  logic               chan_ok;
  logic               base_ok;
  logic               num_hit;
  logic               note_on;
  logic               note_off;
  logic [13:0]        bend_b;
  logic [15:0]        bend_2b;
  logic [15:0]        bend_r;
  logic [15:0]        bend_val;
  logic signed [15:0] rel_delta;
  logic signed [17:0] rel_sum;
  logic [15:0]        rel_val;

  // Candidate test: enable, port, omni or matching channel
  assign chan_ok  = (route_i.channel == 5'd0) ||
                    (route_i.channel == (5'(msg_i.chan) + 5'd1));
  assign base_ok  = route_i.enable && (route_i.port == msg_i.port) && chan_ok;
  assign num_hit  = (route_i.number == msg_i.d1);
  assign note_on  = (msg_i.mtype == MSG_NOTE_ON);
  assign note_off = (msg_i.mtype == MSG_NOTE_OFF);

  // Bend: 2b plus a correction of zero, one or two
  assign bend_b   = {msg_i.d2, msg_i.d1};
  assign bend_2b  = {1'b0, bend_b, 1'b0};
  assign bend_r   = bend_2b + BEND_RND;
  assign bend_val = bend_2b + 16'(bend_r >= BEND_DIV) + 16'(bend_r >= BEND_DIV2);

  // Relative CC: add the table step, clamp to [0, 1.0]
  assign rel_delta = REL_DELTA_LUT[msg_i.d2];
  assign rel_sum   = $signed({2'b00, old_i}) + $signed({{2{rel_delta[15]}}, rel_delta});
  assign rel_val   = rel_sum[17]               ? 16'd0  :
                     (rel_sum > 18'sd32768)    ? ONE_FX : rel_sum[15:0];

  // Select the new value by event mode
  always_comb begin
    upd_o.hit   = 1'b0;
    upd_o.value = old_i;
    if (base_ok) begin
      unique case (route_i.evt)
        EVT_CC_ABS: begin
          if (num_hit) begin
            upd_o.hit   = 1'b1;
            upd_o.value = SCALE7_LUT[msg_i.d2];
          end
        end
        EVT_CC_REL: begin
          if (num_hit) begin
            upd_o.hit   = 1'b1;
            upd_o.value = rel_val;
          end
        end
        EVT_BEND: begin
          if (msg_i.mtype == MSG_BEND) begin
            upd_o.hit   = 1'b1;
            upd_o.value = bend_val;
          end
        end
        EVT_MOMENTARY: begin
          if (num_hit && note_on) begin
            upd_o.hit   = 1'b1;
            upd_o.value = ONE_FX;
          end else if (num_hit && note_off) begin
            upd_o.hit   = 1'b1;
            upd_o.value = 16'd0;
          end
        end
        EVT_TOGGLE: begin
          if (num_hit && note_on) begin
            upd_o.hit   = 1'b1;
            upd_o.value = (old_i < HALF_FX) ? ONE_FX : 16'd0;
          end
        end
        EVT_VELOCITY: begin
          if (num_hit && note_on) begin
            upd_o.hit   = 1'b1;
            upd_o.value = SCALE7_LUT[msg_i.d2];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/midi_control_mapper_core.sv */
// MIDI control mapper top level: route walk sequencer over route and value memories.
// A MIDI message transaction walks every route before the done state loads the
// result register, waiting while the output is stalled; other kinds skip the walk.
// Throughput: one item at a time; the walk visits one route per cycle through the
// registered read port of each memory.
// Reset: control state clears at once; per-entry valid bits make both memories read
// as zero until written, so no clearing pass is needed and items are taken at once.
module midi_control_mapper_core import mcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  route_index_i,
  input  logic        route_enable_i,
  input  logic        route_port_i,
  input  logic [4:0]  route_channel_i,
  input  logic [2:0]  route_event_i,
  input  logic [6:0]  route_number_i,
  input  logic        msg_port_i,
  input  logic [2:0]  msg_type_i,
  input  logic [3:0]  msg_channel_i,
  input  logic [6:0]  msg_data1_i,
  input  logic [6:0]  msg_data2_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        consumed_o,
  output logic [15:0] route_value_o
);

  localparam logic [RIDX_W-1:0] LAST_IDX = RIDX_W'(ROUTES - 1);

  state_e            state_q, state_d;
  logic [RIDX_W-1:0] ptr_q;
  kind_e             kind_q;
  msg_t              msg_q;
  logic              rd_ok_q;
  logic              cons_q;
  logic              out_valid_q;
  logic              out_consumed_q;
  logic [15:0]       out_value_q;

  logic              in_acc;
  kind_e             kind_in;
  logic              idx_ok;
  logic              walk;
  logic              last;
  logic              load_out;
  msg_t              msg_in;
  route_t            route_wdata;

  logic              rt_we;
  logic              rt_re;
  logic [RIDX_W-1:0] rt_raddr;
  logic [ROUTE_W-1:0] rt_rdata;
  logic              val_we;
  logic              val_re;
  logic [RIDX_W-1:0] val_raddr;
  logic [15:0]       val_rdata;
  upd_t              upd;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign kind_in = kind_e'(kind_i);
  assign idx_ok  = (32'(route_index_i) < ROUTES);
  assign walk    = (state_q == S_WALK);
  assign last    = (ptr_q == LAST_IDX);

  assign msg_in.port  = msg_port_i;
  assign msg_in.mtype = msg_type_e'(msg_type_i);
  assign msg_in.chan  = msg_channel_i;
  assign msg_in.d1    = msg_data1_i;
  assign msg_in.d2    = msg_data2_i;

  assign route_wdata.enable  = route_enable_i;
  assign route_wdata.port    = route_port_i;
  assign route_wdata.channel = route_channel_i;
  assign route_wdata.evt     = route_evt_e'(route_event_i);
  assign route_wdata.number  = route_number_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (kind_in == KIND_MSG) ? S_WALK : S_DONE;
        end
      end
      S_WALK: begin
        if (last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory strobes and result load
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    rt_we      = in_acc && (kind_in == KIND_WRITE) && idx_ok;
    rt_re      = (in_acc && (kind_in == KIND_MSG)) || (walk && !last);
    rt_raddr   = walk ? (ptr_q + 1'b1) : '0;
    val_re     = rt_re || (in_acc && (kind_in == KIND_READ));
    val_raddr  = walk ? (ptr_q + 1'b1) :
                 ((kind_in == KIND_READ) ? RIDX_W'(route_index_i) : '0);
    val_we     = walk && upd.hit;
    load_out   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        ptr_q <= '0;
      end else if (walk && !last) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the transaction and collect the consumed flag during the walk
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q  <= kind_in;
      msg_q   <= msg_in;
      rd_ok_q <= idx_ok;
      cons_q  <= 1'b0;
    end else if (val_we) begin
      cons_q <= 1'b1;
    end
    if (load_out) begin
      out_consumed_q <= (kind_q == KIND_MSG) && cons_q;
      out_value_q    <= ((kind_q == KIND_READ) && rd_ok_q) ? val_rdata : 16'd0;
    end
  end

  mcm_ram #(
    .Width (ROUTE_W),
    .Depth (ROUTES)
  ) u_route_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (rt_we),
    .waddr_i (RIDX_W'(route_index_i)),
    .wdata_i (route_wdata),
    .re_i    (rt_re),
    .raddr_i (rt_raddr),
    .rdata_o (rt_rdata)
  );

  mcm_ram #(
    .Width (16),
    .Depth (ROUTES)
  ) u_value_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (val_we),
    .waddr_i (ptr_q),
    .wdata_i (upd.value),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  mcm_update u_update (
    .route_i (route_t'(rt_rdata)),
    .old_i   (val_rdata),
    .msg_i   (msg_q),
    .upd_o   (upd)
  );

  assign out_valid_o   = out_valid_q;
  assign consumed_o    = out_consumed_q;
  assign route_value_o = out_value_q;

  // The walk advances one route per cycle until the last one
  a_walk_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk && !last |=> walk && (ptr_q == $past(ptr_q) + 1'b1))
    else $error("route walk did not advance by one");

  // Write-back never collides with the read of the next route
  a_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    val_we && val_re |-> ptr_q != val_raddr)
    else $error("value memory read and write hit the same entry");

  // A written value stays within 0 to 1.0
  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    val_we |-> upd.value <= ONE_FX)
    else $error("updated value above full scale");

  // A result never flags consumption and carries a value at once
  a_result_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_consumed_q |-> out_value_q == 16'd0)
    else $error("consumed result carries a route value");

endmodule
